/* hw/rtl/pwm_led_dimmer_with_breathing_unit_assert.svh */
// Assertion macros used by the top-level RTL file.
`ifndef PWM_LED_DIMMER_WITH_BREATHING_UNIT_ASSERT_SVH
`define PWM_LED_DIMMER_WITH_BREATHING_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PWMD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold whenever the trigger is true.
`define PWMD_ASSERT_IMPLIES(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

`endif

/* hw/rtl/pwmd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pwmd_pkg;

  localparam logic [6:0] DUTY_FULL = 7'd100;
  localparam logic [6:0] DUTY_RESET = 7'd50;
  localparam logic [3:0] BLANK_DIGIT = 4'd10;
  localparam logic [3:0] DIGIT_BASE = 4'd10;

  localparam logic [5:0] DUTY_STEP_RESET = 6'd10;
  localparam logic [7:0] TICKS_PER_CONTROL_RESET = 8'd100;
  localparam logic [3:0] BREATH_DIVIDER_RESET = 4'd3;

  localparam int IN_DATA_W = 8;
  localparam int OUT_DATA_W = 24;
  localparam int ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_DUTY_STEP = 2'd0,
    REG_TICKS_PER_CONTROL = 2'd1,
    REG_BREATH_DIVIDER = 2'd2
  } reg_index_t;

  typedef enum logic [1:0] {
    DB_IDLE = 2'd0,
    DB_CONFIRM = 2'd1,
    DB_HELD = 2'd2
  } db_state_t;

  typedef enum logic [2:0] {
    KEY_NONE = 3'd0,
    KEY_OFF = 3'd1,
    KEY_DIM = 3'd2,
    KEY_BRIGHT = 3'd3,
    KEY_AUTO = 3'd4
  } key_event_t;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    digit_t hundreds;
    digit_t tens;
    digit_t ones;
  } digits_t;

  typedef struct packed {
    logic [5:0] duty_step;
    logic [3:0] breath_divider;
  } ctrl_cfg_t;

  typedef struct packed {
    logic [6:0] duty_cur;
    logic [6:0] duty_next;
    logic auto_next;
    digits_t digits_next;
  } ctrl_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/pwmd_digits.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwmd_digits
  import pwmd_pkg::*;
(
  input  wire logic [6:0] value,
  output digits_t         digits
);

  logic        hundred;
  logic [6:0]  rest;
  logic [14:0] scaled;
  digit_t      tens;
  logic [6:0]  tens_x10;

  // The tens digit is rest * 205 / 2048, exact for rest below 100.
  always_comb begin
    hundred = (value >= DUTY_FULL);
    rest = hundred ? (value - DUTY_FULL) : value;
    scaled = 15'(rest) * 15'd205;
    tens = scaled[14:11];
    tens_x10 = 7'(tens) * 7'(DIGIT_BASE);
    digits.hundreds = {3'b000, hundred};
    digits.tens = tens;
    digits.ones = 4'(rest - tens_x10);
  end

endmodule

`default_nettype wire

/* hw/rtl/pwmd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none

module pwmd_ctrl
  import pwmd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       step,
  input  wire logic [3:0] keys,
  input  wire ctrl_cfg_t  cfg,
  output ctrl_stat_t      stat
);

  db_state_t  db_state, db_state_next;
  key_event_t key, key_event;

  logic [6:0] duty, duty_next;
  logic       breathing, breathing_next;
  logic [3:0] breath_subcount, breath_subcount_next;
  logic [6:0] breath_level, breath_level_next;
  logic       breath_rising, breath_rising_next;
  digits_t    shown, shown_next;

  logic       handled;
  logic       refresh;
  logic [7:0] bright_sum;
  logic [3:0] sub_inc;
  logic [6:0] level_inc;
  digits_t    fresh_digits;

  always_comb begin
    if (keys[0]) begin
      key = KEY_OFF;
    end else if (keys[1]) begin
      key = KEY_DIM;
    end else if (keys[2]) begin
      key = KEY_BRIGHT;
    end else if (keys[3]) begin
      key = KEY_AUTO;
    end else begin
      key = KEY_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      db_state <= DB_IDLE;
    end else if (step) begin
      db_state <= db_state_next;
    end
  end

  always_comb begin
    db_state_next = db_state;
    key_event = KEY_NONE;
    case (db_state)
      DB_IDLE: begin
        if (key != KEY_NONE) begin
          db_state_next = DB_CONFIRM;
        end
      end
      DB_CONFIRM: begin
        if (key == KEY_NONE) begin
          db_state_next = DB_IDLE;
        end else begin
          key_event = key;
          db_state_next = DB_HELD;
        end
      end
      default: begin
        if (key == KEY_NONE) begin
          db_state_next = DB_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    duty_next = duty;
    breathing_next = breathing;
    breath_subcount_next = breath_subcount;
    breath_level_next = breath_level;
    breath_rising_next = breath_rising;
    handled = !breathing || (key_event == KEY_AUTO);
    refresh = handled;
    bright_sum = 8'(duty) + 8'(cfg.duty_step);
    sub_inc = breath_subcount + 4'd1;
    level_inc = breath_level + 7'd1;
    if (handled) begin
      case (key_event)
        KEY_OFF: begin
          duty_next = '0;
        end
        KEY_DIM: begin
          duty_next = (duty >= 7'(cfg.duty_step)) ? (duty - 7'(cfg.duty_step)) : '0;
        end
        KEY_BRIGHT: begin
          duty_next = (bright_sum <= 8'(DUTY_FULL)) ? bright_sum[6:0] : DUTY_FULL;
        end
        KEY_AUTO: begin
          breathing_next = !breathing;
        end
        default: begin
        end
      endcase
    end
    if (breathing_next) begin
      if (sub_inc >= cfg.breath_divider) begin
        breath_subcount_next = '0;
        if (level_inc > DUTY_FULL) begin
          breath_level_next = '0;
          breath_rising_next = !breath_rising;
        end else begin
          breath_level_next = level_inc;
        end
        duty_next = breath_rising_next ? breath_level_next : (DUTY_FULL - breath_level_next);
        refresh = 1'b1;
      end else begin
        breath_subcount_next = sub_inc;
      end
    end
  end

  pwmd_digits u_digits (
    .value  (duty_next),
    .digits (fresh_digits)
  );

  assign shown_next = refresh ? fresh_digits : shown;

  always_ff @(posedge clk) begin
    if (rst) begin
      duty <= DUTY_RESET;
      breathing <= 1'b0;
      breath_subcount <= '0;
      breath_level <= '0;
      breath_rising <= 1'b1;
      shown <= '{BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT};
    end else if (step) begin
      duty <= duty_next;
      breathing <= breathing_next;
      breath_subcount <= breath_subcount_next;
      breath_level <= breath_level_next;
      breath_rising <= breath_rising_next;
      shown <= shown_next;
    end
  end

  always_comb begin
    stat.duty_cur = duty;
    if (step) begin
      stat.duty_next = duty_next;
      stat.auto_next = breathing_next;
      stat.digits_next = shown_next;
    end else begin
      stat.duty_next = duty;
      stat.auto_next = breathing;
      stat.digits_next = shown;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/pwm_led_dimmer_with_breathing_unit.sv */
// PWM LED dimmer with a breathing mode and a three-digit duty display.
// The input stream carries one item per 100 us tick; s_tdata[3:0] holds the
// keys (off, dim, bright, auto from the lowest bit up). Each accepted request
// produces exactly one result on the output stream with the LED drive, the
// current duty, the three shown digits (10 is blank) and the auto flag.
// Every ticks_per_control ticks a control step debounces the keys and updates
// the duty or the breathing ramp in the same tick.
// A result appears in the cycle after its request is accepted. One request is
// accepted every cycle unless stalled; the whole tick update is a single pass of
// small counters and compares between state registers and the output register.
// The output register lets a new request in while the result is taken in the
// same cycle. When the receiver stalls with a result held, s_tready drops and
// no state advances until the result is taken.
// The APB port writes duty_step at 0x0, ticks_per_control at 0x4 and
// breath_divider at 0x8; writes are meant for idle periods only.
// Reset clears the stream, sets the duty to 50, blanks the digits and loads
// the register defaults.
`timescale 1ns / 1ps
`default_nettype none

`include "pwm_led_dimmer_with_breathing_unit_assert.svh"

module pwm_led_dimmer_with_breathing_unit
  import pwmd_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // s_tdata fields from bit 0: keys_pressed[3:0], zero fill.
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  // m_tdata fields from bit 0: led_on, duty_level[6:0], digit_hundreds[3:0],
  // digit_tens[3:0], digit_ones[3:0], auto_mode, zero fill.
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic       s_accept;
  logic       cfg_write;
  reg_index_t cfg_index;

  logic [5:0] duty_step;
  logic [7:0] ticks_per_control;
  logic [3:0] breath_divider;

  logic [6:0] pwm_phase, pwm_phase_next;
  logic [7:0] tick_prescale, tick_prescale_next;
  logic [7:0] prescale_inc;
  logic       control_due;
  logic       led_on;

  ctrl_cfg_t  ctrl_cfg;
  ctrl_stat_t ctrl_stat;

  assign pready = 1'b1;
  assign s_tready = !m_tvalid || m_tready;
  assign s_accept = s_tvalid && s_tready;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      duty_step <= DUTY_STEP_RESET;
      ticks_per_control <= TICKS_PER_CONTROL_RESET;
      breath_divider <= BREATH_DIVIDER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_DUTY_STEP: begin
          duty_step <= pwdata[5:0];
        end
        REG_TICKS_PER_CONTROL: begin
          ticks_per_control <= pwdata[7:0];
        end
        REG_BREATH_DIVIDER: begin
          breath_divider <= pwdata[3:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (cfg_index)
      REG_DUTY_STEP: begin
        prdata = {26'd0, duty_step};
      end
      REG_TICKS_PER_CONTROL: begin
        prdata = {24'd0, ticks_per_control};
      end
      REG_BREATH_DIVIDER: begin
        prdata = {28'd0, breath_divider};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_comb begin
    pwm_phase_next = (pwm_phase >= DUTY_FULL - 7'd1) ? '0 : (pwm_phase + 7'd1);
    prescale_inc = tick_prescale + 8'd1;
    control_due = (prescale_inc >= ticks_per_control);
    tick_prescale_next = control_due ? '0 : prescale_inc;
    led_on = (pwm_phase_next < ctrl_stat.duty_cur);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_phase <= '0;
      tick_prescale <= '0;
    end else if (s_accept) begin
      pwm_phase <= pwm_phase_next;
      tick_prescale <= tick_prescale_next;
    end
  end

  assign ctrl_cfg.duty_step = duty_step;
  assign ctrl_cfg.breath_divider = breath_divider;

  pwmd_ctrl u_ctrl (
    .clk  (clk),
    .rst  (rst),
    .step (s_accept && control_due),
    .keys (s_tdata[3:0]),
    .cfg  (ctrl_cfg),
    .stat (ctrl_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      m_tdata <= {3'b000, ctrl_stat.auto_next, ctrl_stat.digits_next.ones,
                  ctrl_stat.digits_next.tens, ctrl_stat.digits_next.hundreds,
                  ctrl_stat.duty_next, led_on};
    end
  end

  `PWMD_ASSERT_IMPLIES(a_stall_only_when_full, !s_tready, m_tvalid && !m_tready,
    "input stalled without a held result")
  `PWMD_ASSERT_IMPLIES(a_duty_in_range, m_tvalid, m_tdata[7:1] <= DUTY_FULL,
    "duty above full scale")
  `PWMD_ASSERT_IMPLIES(a_blank_together, m_tvalid,
    (m_tdata[11:8] == BLANK_DIGIT) == (m_tdata[19:16] == BLANK_DIGIT),
    "digits partly blank")
  `PWMD_ASSERT_IMPLIES(a_hundred_is_full, m_tvalid && (m_tdata[11:8] == 4'd1),
    (m_tdata[15:12] == 4'd0) && (m_tdata[19:16] == 4'd0),
    "hundreds digit set with nonzero lower digits")

endmodule

`default_nettype wire

/* tb/pwm_led_dimmer_with_breathing_unit_tb.sv */
`timescale 1ns / 1ps

module pwm_led_dimmer_with_breathing_unit_tb;
  import pwmd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_STALL = 80;

  typedef struct packed {
    logic [2:0] fill;
    logic       auto_on;
    digit_t     ones;
    digit_t     tens;
    digit_t     hundreds;
    logic [6:0] duty;
    logic       led;
  } dimmer_frame_t;

  class dimmer_tracker;
    logic [5:0] duty_step;
    logic [7:0] ticks_per_control;
    logic [3:0] breath_divider;
    logic [6:0] phase;
    logic [7:0] prescale;
    db_state_t  db;
    logic [6:0] duty;
    logic       breathing;
    logic       rising;
    logic [3:0] subcount;
    logic [6:0] level;
    digits_t    shown;
    dimmer_frame_t pending_frames[$];
    int unsigned faults;
    int unsigned control_steps;
    int unsigned breath_turns;

    function new();
      duty_step = DUTY_STEP_RESET;
      ticks_per_control = TICKS_PER_CONTROL_RESET;
      breath_divider = BREATH_DIVIDER_RESET;
      phase = '0;
      prescale = '0;
      db = DB_IDLE;
      duty = DUTY_RESET;
      breathing = 1'b0;
      rising = 1'b1;
      subcount = '0;
      level = '0;
      shown = {BLANK_DIGIT, BLANK_DIGIT, BLANK_DIGIT};
      faults = 0;
      control_steps = 0;
      breath_turns = 0;
    endfunction

    function void load_reg(reg_index_t idx, logic [31:0] value);
      case (idx)
        REG_DUTY_STEP: duty_step = value[5:0];
        REG_TICKS_PER_CONTROL: ticks_per_control = value[7:0];
        REG_BREATH_DIVIDER: breath_divider = value[3:0];
        default: ;
      endcase
    endfunction

    function int reg_value(reg_index_t idx);
      case (idx)
        REG_DUTY_STEP: return int'(duty_step);
        REG_TICKS_PER_CONTROL: return int'(ticks_per_control);
        REG_BREATH_DIVIDER: return int'(breath_divider);
        default: return 0;
      endcase
    endfunction

    function void tally(string what, int want_v, int got_v);
      if (want_v != got_v) begin
        faults++;
        if (faults <= 10) begin
          $display("Mismatch in %s at %0t: expected %0d, got %0d", what, $time, want_v, got_v);
        end
      end
    endfunction

    function key_event_t lowest_key(logic [3:0] keys);
      if (keys[0]) return KEY_OFF;
      if (keys[1]) return KEY_DIM;
      if (keys[2]) return KEY_BRIGHT;
      if (keys[3]) return KEY_AUTO;
      return KEY_NONE;
    endfunction

    function void refresh_digits();
      int d;
      d = int'(duty);
      shown.ones = digit_t'(d % int'(DIGIT_BASE));
      d = d / int'(DIGIT_BASE);
      shown.tens = digit_t'(d % int'(DIGIT_BASE));
      d = d / int'(DIGIT_BASE);
      shown.hundreds = digit_t'(d % int'(DIGIT_BASE));
    endfunction

    function void control_step(logic [3:0] keys);
      key_event_t k;
      key_event_t ev;
      k = lowest_key(keys);
      ev = KEY_NONE;
      control_steps++;
      case (db)
        DB_IDLE: if (k != KEY_NONE) db = DB_CONFIRM;
        DB_CONFIRM: begin
          if (k == KEY_NONE) begin
            db = DB_IDLE;
          end else begin
            ev = k;
            db = DB_HELD;
          end
        end
        default: if (k == KEY_NONE) db = DB_IDLE;
      endcase
      if (!breathing || ev == KEY_AUTO) begin
        case (ev)
          KEY_OFF: duty = '0;
          KEY_DIM: duty = (duty >= duty_step) ? duty - duty_step : 7'd0;
          KEY_BRIGHT: begin
            duty = (int'(duty) + int'(duty_step) <= int'(DUTY_FULL)) ?
                   duty + duty_step : DUTY_FULL;
          end
          KEY_AUTO: breathing = !breathing;
          default: ;
        endcase
        refresh_digits();
      end
      if (breathing) begin
        subcount = subcount + 4'd1;
        if (subcount >= breath_divider) begin
          subcount = '0;
          level = level + 7'd1;
          if (level > DUTY_FULL) begin
            rising = !rising;
            level = '0;
            breath_turns++;
          end
          duty = rising ? level : DUTY_FULL - level;
          refresh_digits();
        end
      end
    endfunction

    function void note_keys(logic [3:0] keys);
      dimmer_frame_t f;
      f = '0;
      phase = (int'(phase) == int'(DUTY_FULL) - 1) ? 7'd0 : phase + 7'd1;
      f.led = (phase < duty);
      prescale = prescale + 8'd1;
      if (prescale >= ticks_per_control) begin
        prescale = '0;
        control_step(keys);
      end
      f.duty = duty;
      f.hundreds = shown.hundreds;
      f.tens = shown.tens;
      f.ones = shown.ones;
      f.auto_on = breathing;
      pending_frames.push_back(f);
    endfunction

    function void check_frame(logic [OUT_DATA_W-1:0] data);
      dimmer_frame_t got;
      dimmer_frame_t want;
      got = data;
      if (pending_frames.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("Result with no request pending at %0t: %h", $time, data);
        end
        return;
      end
      want = pending_frames.pop_front();
      tally("led_on", want.led, got.led);
      tally("duty_level", want.duty, got.duty);
      tally("digit_hundreds", want.hundreds, got.hundreds);
      tally("digit_tens", want.tens, got.tens);
      tally("digit_ones", want.ones, got.ones);
      tally("auto_mode", want.auto_on, got.auto_on);
      tally("zero fill", want.fill, got.fill);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_DATA_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  dimmer_tracker tracker = new();
  int unsigned accepted_count = 0;
  int unsigned received_count = 0;
  int unsigned settings_count = 0;
  int unsigned long_stalls = 0;
  int unsigned idle_cycles = 0;

  localparam logic [3:0] DIRECTED_KEYS [26] = '{
    4'h0, 4'hF, 4'hF, 4'h0, 4'h2, 4'h2, 4'h0, 4'h4, 4'h4, 4'h0,
    4'h4, 4'h4, 4'h0, 4'h4, 4'h4, 4'h4, 4'h0, 4'h8, 4'h8, 4'h0,
    4'h6, 4'h6, 4'h0, 4'h8, 4'h8, 4'h0
  };

  pwm_led_dimmer_with_breathing_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_keys(input logic [3:0] keys);
    int gap;
    gap = (accepted_count % 80 < 25) ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(IN_DATA_W - 4){1'b0}}, keys};
    do @(posedge clk); while (!s_tready);
    tracker.note_keys(keys);
    accepted_count++;
  endtask

  task automatic write_reg(input reg_index_t idx, input logic [31:0] value);
    logic [31:0] readback;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    tracker.load_reg(idx, value);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    tracker.tally("register readback", tracker.reg_value(idx), int'(readback));
  endtask

  task automatic set_regs(input int step, input int ticks, input int divider);
    s_tvalid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    write_reg(REG_DUTY_STEP, step);
    write_reg(REG_TICKS_PER_CONTROL, ticks);
    write_reg(REG_BREATH_DIVIDER, divider);
    settings_count++;
  endtask

  // Mostly clean press, hold and release sequences sized to the control
  // period, with bursts of random key noise in between.
  task automatic drive_phase(input int count);
    int unit;
    int len;
    int pause;
    int n;
    int i;
    logic [3:0] keys;
    unit = (tracker.ticks_per_control == 0) ? 1 : int'(tracker.ticks_per_control);
    n = 0;
    while (n < count) begin
      if ($urandom_range(0, 3) != 0) begin
        keys = $urandom_range(0, 1) ? 4'(1 << $urandom_range(0, 3)) : 4'($urandom_range(1, 15));
        len = unit * $urandom_range(2, 3) + $urandom_range(0, unit - 1);
        pause = unit * $urandom_range(1, 2);
        for (i = 0; i < len + pause && n < count; i++) begin
          send_keys((i < len) ? keys : 4'h0);
          n++;
        end
      end else begin
        len = $urandom_range(1, 2 * unit);
        for (i = 0; i < len && n < count; i++) begin
          send_keys(4'($urandom_range(0, 15)));
          n++;
        end
      end
    end
  endtask

  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (received_count == 300 || received_count == 1100) begin
        gap = LONG_STALL;
        long_stalls++;
      end else begin
        gap = (received_count % 70 < 20) ? 0 : $urandom_range(0, 10);
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      tracker.check_frame(m_tdata);
      received_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("Timeout: no stream transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int i;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    drive_phase(250);

    set_regs(50, 1, 1);
    if (tracker.breathing) begin
      send_keys(4'h0);
      send_keys(4'h8);
      send_keys(4'h8);
    end
    foreach (DIRECTED_KEYS[k]) send_keys(DIRECTED_KEYS[k]);

    set_regs(1, 1, 1);
    send_keys(4'h0);
    if (!tracker.breathing) begin
      send_keys(4'h8);
      send_keys(4'h8);
    end
    for (i = 0; i < 260; i++) send_keys(4'($urandom_range(0, 7)));

    set_regs(0, 0, 0);
    drive_phase(150);

    for (i = 0; i < 3; i++) begin
      set_regs($urandom_range(1, 50), $urandom_range(1, 4), $urandom_range(1, 15));
      drive_phase(170);
    end

    set_regs(50, 255, 15);
    drive_phase(550);

    s_tvalid <= 1'b0;
    while (tracker.pending_frames.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Run covered %0d key ticks, %0d results and %0d register settings.",
             accepted_count, received_count, settings_count);
    $display("Control steps %0d, ramp reversals %0d, long output stalls %0d, mismatches %0d.",
             tracker.control_steps, tracker.breath_turns, long_stalls, tracker.faults);
    if (tracker.faults == 0 && tracker.pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pwmd_pkg.sv
hw/rtl/pwmd_digits.sv
hw/rtl/pwmd_ctrl.sv
hw/rtl/pwm_led_dimmer_with_breathing_unit.sv
tb/pwm_led_dimmer_with_breathing_unit_tb.sv
